// File: hdl/heightfield_normal_and_band_defines.svh
// Assertion macros shared by the RTL of the height-field normal block.
// Every check is sampled on the rising edge of clk and ignored while rst_n is low.
`ifndef HEIGHTFIELD_NORMAL_AND_BAND_DEFINES_SVH
`define HEIGHTFIELD_NORMAL_AND_BAND_DEFINES_SVH

`ifndef SYNTHESIS
`define HFNB_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define HFNB_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define HFNB_ASSERT_ALWAYS(lbl, expr)
`define HFNB_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: hdl/hfnb_pkg.sv
`default_nettype none

package hfnb_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        REG_GRID_SIZE = 2'd0,
        REG_SPACING   = 2'd1,
        REG_SCALE     = 2'd2
    } reg_idx_t;

    // Neighbour reads per point: left, right, down, up, centre
    localparam int          NB_COUNT   = 5;
    localparam logic [2:0]  RD_DONE    = 3'd5;
    localparam logic [1:0]  SQ_INIT    = 2'd3;
    localparam logic [3:0]  Q_TOP_BIT  = 4'd14;
    localparam logic [14:0] Q_MAX      = 15'h7FFF;
    localparam int          ACC_W      = 86;
    localparam int          NUM_BANDS  = 7;
    localparam logic [2:0]  BAND_NONE  = 3'd7;
    localparam logic [6:0]  PCT_SCALE  = 7'd100;

    localparam logic [6:0] BAND_PCT [NUM_BANDS] =
        '{7'd10, 7'd18, 7'd22, 7'd40, 7'd60, 7'd75, 7'd88};

    localparam logic [8:0]  GRID_RST    = 9'd2;
    localparam logic [15:0] SPACING_RST = 16'd256;
    localparam logic [15:0] SCALE_RST   = 16'hFFFF;

endpackage

`default_nettype wire

// File: hdl/heightfield_normal_and_band.sv
`default_nettype none
// Channel   | Dir | Fields                                              | Handshake
// s_axis    | in  | tdata[15:0] height                                  | tvalid/tready
// m_axis    | out | tdata row,col,normal_x/y/z,band; tlast run_end;     | tvalid/tready
//           |     | tuser grid_done                                     |
// apb       | in  | grid_size @0x0, sample_spacing @0x4, height_scale @0x8 | psel/penable
//
// An item that causes no result (first grid row) leaves the block idle for the next item.
// Each result point passes ST_READ for the five neighbour reads through the single
// read port of the row store, ST_SQ for the squares on the one shared 16x16
// multiplier, ST_SEARCH for the bit-serial magnitude search of the three components
// and ST_EMIT to load the output. A last-row item causes up to three points.
// Reset clears the counters and configuration registers, not the datapath or row store.
// A stalled output holds only the item after it; input is taken again once queued points drain.
`include "heightfield_normal_and_band_defines.svh"

module heightfield_normal_and_band #(
    parameter int MAX_SIDE    = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // height sample
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] height
    // result point
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] row, [15:8] col, [31:16] normal_x, [47:32] normal_y,
    // [62:48] normal_z, [65:63] band, [71:66] zero
    output logic [71:0]      m_axis_tdata,
    output logic             m_axis_tlast,   // run_end
    output logic             m_axis_tuser,   // [0] grid_done
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import hfnb_pkg::*;

    localparam int CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int NW    = $clog2(MAX_SIDE + 1);
    localparam int DEPTH = 3 * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [8:0]  grid_size_reg;
    logic [15:0] spacing_reg;
    logic [15:0] scale_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_GRID_SIZE: prdata = {23'd0, grid_size_reg};
            REG_SPACING:   prdata = {16'd0, spacing_reg};
            REG_SCALE:     prdata = {16'd0, scale_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Clamp the side to [2, MAX_SIDE]
    logic [NW-1:0] side;
    logic [CW-1:0] nm1;

    always_comb
    begin
        if (grid_size_reg < 9'd2)
            side = NW'(2);
        else if (32'(grid_size_reg) > MAX_SIDE)
            side = NW'(MAX_SIDE);
        else
            side = NW'(grid_size_reg);
        nm1 = CW'(side - NW'(1));
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [1:0] slot_inc(input logic [1:0] sl);
        return (sl == 2'd2) ? 2'd0 : sl + 2'd1;
    endfunction

    function automatic logic [1:0] slot_dec(input logic [1:0] sl);
        return (sl == 2'd0) ? 2'd2 : sl - 2'd1;
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic [1:0] sl, input logic [CW-1:0] cl);
        return AW'(sl) * AW'(MAX_SIDE) + AW'(cl);
    endfunction

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t        state_reg, state_next;
    logic [CW-1:0] row_reg, col_reg;
    logic [1:0]    slot_reg;
    logic [2:0]    pend_reg;
    logic [2:0]    rd_cnt_reg;
    logic [1:0]    sq_cnt_reg;
    logic [3:0]    k_reg;
    logic          m_tvalid_reg;

    logic          s_acc;
    logic          last_row;
    logic [2:0]    acc_mask;
    logic          out_load;
    logic          rd_en;
    logic          mem_we;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign mem_we        = s_acc;
    assign m_axis_tvalid = m_tvalid_reg;

    // Points caused by the sample at (row, col): one row above, then last-row points
    always_comb
    begin
        last_row    = (row_reg == nm1);
        acc_mask[0] = (row_reg != '0);
        acc_mask[1] = last_row && (col_reg != '0);
        acc_mask[2] = last_row && (col_reg == nm1);
    end

    // Current point: lowest pending entry
    logic [CW-1:0] acc_row_reg, acc_col_reg;
    logic [1:0]    acc_slot_reg;
    logic [2:0]    sel;
    logic [2:0]    pend_left;
    logic [CW-1:0] p_row, p_col;
    logic [1:0]    p_slot;
    logic          p_done;

    always_comb
    begin
        sel    = 3'b100;
        p_row  = acc_row_reg;
        p_col  = acc_col_reg;
        p_slot = acc_slot_reg;
        p_done = 1'b0;
        if (pend_reg[0])
        begin
            sel    = 3'b001;
            p_row  = acc_row_reg - 1'b1;
            p_slot = slot_dec(acc_slot_reg);
        end
        else if (pend_reg[1])
        begin
            sel   = 3'b010;
            p_col = acc_col_reg - 1'b1;
        end
        else
        begin
            p_done = 1'b1;
        end
        pend_left = pend_reg & ~sel;
    end

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        rd_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && (acc_mask != 3'd0))
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                rd_en = (rd_cnt_reg != RD_DONE);
                if (rd_cnt_reg == RD_DONE)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (sq_cnt_reg == SQ_INIT)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (k_reg == 4'd0)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = (pend_left == 3'd0) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grid_size_reg <= GRID_RST;
            spacing_reg   <= SPACING_RST;
            scale_reg     <= SCALE_RST;
            row_reg       <= '0;
            col_reg       <= '0;
            slot_reg      <= 2'd0;
            pend_reg      <= 3'd0;
            rd_cnt_reg    <= 3'd0;
            sq_cnt_reg    <= 2'd0;
            k_reg         <= 4'd0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Writing the side restarts the grid
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_GRID_SIZE:
                    begin
                        grid_size_reg <= pwdata[8:0];
                        row_reg       <= '0;
                        col_reg       <= '0;
                        slot_reg      <= 2'd0;
                    end
                    REG_SPACING: spacing_reg <= pwdata[15:0];
                    REG_SCALE:   scale_reg   <= pwdata[15:0];
                    default:     ;
                endcase
            end
            else if (s_acc)
            begin
                if (col_reg == nm1)
                begin
                    col_reg <= '0;
                    if (row_reg == nm1)
                    begin
                        row_reg  <= '0;
                        slot_reg <= 2'd0;
                    end
                    else
                    begin
                        row_reg  <= row_reg + 1'b1;
                        slot_reg <= slot_inc(slot_reg);
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            if (s_acc)
                pend_reg <= acc_mask;
            else if (out_load)
                pend_reg <= pend_left;

            rd_cnt_reg <= (state_reg == ST_READ) ? rd_cnt_reg + 3'd1 : 3'd0;
            sq_cnt_reg <= (state_reg == ST_SQ) ? sq_cnt_reg + 2'd1 : 2'd0;

            if (state_reg == ST_SQ)
                k_reg <= Q_TOP_BIT;
            else if (state_reg == ST_SEARCH && k_reg != 4'd0)
                k_reg <= k_reg - 4'd1;

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_axis_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Row store: three rows, one write and one registered read port
    // ------------------------------------------------------------------
    logic [HW-1:0] row_store_mem [DEPTH];
    logic [HW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;

    always_comb
    begin
        case (rd_cnt_reg)
            3'd0:    rd_addr = mem_addr(p_slot, (p_col == '0) ? p_col : p_col - 1'b1);
            3'd1:    rd_addr = mem_addr(p_slot, (p_col == nm1) ? p_col : p_col + 1'b1);
            3'd2:    rd_addr = mem_addr((p_row == '0) ? p_slot : slot_dec(p_slot), p_col);
            3'd3:    rd_addr = mem_addr((p_row == nm1) ? p_slot : slot_inc(p_slot), p_col);
            default: rd_addr = mem_addr(p_slot, p_col);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_store_mem[mem_addr(slot_reg, col_reg)] <= s_axis_tdata[HW-1:0];
        if (rd_en)
            rd_data_reg <= row_store_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [15:0]             nb_reg [NB_COUNT];   // left, right, down, up, centre
    logic [31:0]             sq_reg [3];
    logic signed [ACC_W-1:0] s_reg;
    logic signed [ACC_W-1:0] a_reg [3];
    logic signed [ACC_W-1:0] b_reg [3];
    logic [14:0]             q_reg [3];
    logic                    zero_reg;
    logic [2:0]              band_reg;
    logic [71:0]             out_data_reg;
    logic                    out_last_reg;
    logic                    out_user_reg;

    logic        neg_x, neg_y;
    logic [15:0] mag_x, mag_y, mul_op;
    logic [2:0]  band_now;

    always_comb
    begin
        neg_x  = nb_reg[0] < nb_reg[1];
        neg_y  = nb_reg[2] < nb_reg[3];
        mag_x  = neg_x ? nb_reg[1] - nb_reg[0] : nb_reg[0] - nb_reg[1];
        mag_y  = neg_y ? nb_reg[3] - nb_reg[2] : nb_reg[2] - nb_reg[3];
        case (sq_cnt_reg)
            2'd0:    mul_op = mag_x;
            2'd1:    mul_op = mag_y;
            default: mul_op = spacing_reg;
        endcase
    end

    // First threshold that the height does not exceed
    always_comb
    begin
        band_now = BAND_NONE;
        for (int i = NUM_BANDS - 1; i >= 0; i--)
        begin
            if (23'(nb_reg[4]) * 23'(PCT_SCALE) <= 23'(BAND_PCT[i]) * 23'(scale_reg))
                band_now = 3'(i);
        end
    end

    // Sum of squares, all terms scaled to a common base
    logic signed [ACC_W-1:0] s_sum;
    assign s_sum = ((ACC_W'(sq_reg[0]) + ACC_W'(sq_reg[1])) << 16) + (ACC_W'(sq_reg[2]) << 2);

    // One step of the search per lane: try the next bit of q while tracking
    // A = t*t*S and B = t*S for t = 2q - 1, and keep it where A <= m*m*2^32
    logic signed [ACC_W-1:0] m_val [3];
    logic signed [ACC_W-1:0] cand  [3];
    logic [2:0]              fit;
    logic [4:0]              sh_b, sh_s, sh_u;

    always_comb
    begin
        sh_b     = {1'b0, k_reg} + 5'd2;
        sh_s     = ({1'b0, k_reg} << 1) + 5'd2;
        sh_u     = {1'b0, k_reg} + 5'd1;
        m_val[0] = ACC_W'(sq_reg[0]) << 48;
        m_val[1] = ACC_W'(sq_reg[1]) << 48;
        m_val[2] = ACC_W'(sq_reg[2]) << 34;
        for (int i = 0; i < 3; i++)
        begin
            cand[i] = a_reg[i] + (b_reg[i] <<< sh_b) + (s_reg <<< sh_s);
            fit[i]  = (cand[i] <= m_val[i]);
        end
    end

    logic [15:0] nx, ny;
    logic [14:0] nz;

    always_comb
    begin
        nx = zero_reg ? 16'd0 : (neg_x ? 16'd0 - {1'b0, q_reg[0]} : {1'b0, q_reg[0]});
        ny = zero_reg ? 16'd0 : (neg_y ? 16'd0 - {1'b0, q_reg[1]} : {1'b0, q_reg[1]});
        nz = zero_reg ? Q_MAX : q_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            acc_row_reg  <= row_reg;
            acc_col_reg  <= col_reg;
            acc_slot_reg <= slot_reg;
        end

        if (state_reg == ST_READ && rd_cnt_reg != 3'd0)
            nb_reg[rd_cnt_reg - 3'd1] <= 16'(rd_data_reg);

        if (state_reg == ST_SQ)
        begin
            if (sq_cnt_reg != SQ_INIT)
                sq_reg[sq_cnt_reg] <= 32'(mul_op) * 32'(mul_op);
            if (sq_cnt_reg == 2'd0)
                band_reg <= band_now;
            if (sq_cnt_reg == SQ_INIT)
            begin
                s_reg    <= s_sum;
                zero_reg <= (s_sum == '0);
                for (int i = 0; i < 3; i++)
                begin
                    a_reg[i] <= s_sum;
                    b_reg[i] <= -s_sum;
                    q_reg[i] <= 15'd0;
                end
            end
        end

        if (state_reg == ST_SEARCH)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (fit[i])
                begin
                    a_reg[i]        <= cand[i];
                    b_reg[i]        <= b_reg[i] + (s_reg <<< sh_u);
                    q_reg[i][k_reg] <= 1'b1;
                end
            end
        end

        if (out_load)
        begin
            out_data_reg <= {6'd0, band_reg, nz, ny, nx, 8'(p_col), 8'(p_row)};
            out_last_reg <= (pend_left == 3'd0);
            out_user_reg <= p_done;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;
    assign m_axis_tuser = out_user_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `HFNB_ASSERT_ALWAYS(a_no_rw_overlap, !(mem_we && rd_en))
    `HFNB_ASSERT_ALWAYS(a_busy_has_point, (state_reg == ST_IDLE) || (pend_reg != 3'd0))
    `HFNB_ASSERT_ALWAYS(a_done_is_last, !(m_axis_tvalid && m_axis_tuser) || m_axis_tlast)
    `HFNB_ASSERT_NEXT(a_search_ends, (state_reg == ST_SEARCH) && (k_reg == 4'd0), state_reg == ST_EMIT)

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hfnb_pkg::*;

    // One result point, unpacked from the output item
    typedef struct {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [14:0] nz;
        logic [2:0]  band;
        logic        run_end;
        logic        grid_done;
    } point_t;

    // Directed stimulus row: a register write or a height item, with an
    // optional typed normal_z and band for points whose x and y read zero
    typedef struct {
        bit          is_cfg;
        reg_idx_t    idx;
        logic [31:0] val;
        bit          typed;
        logic [14:0] z_exp;
        logic [2:0]  band_exp;
    } step_t;

    localparam int SIDE_MAX = 256;
    localparam int DIRECTED_LEN = 30;
    localparam int RANDOM_ITEMS = 400;
    localparam int SETTLE_CYCLES = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;  // [7:0] row, [15:8] col, [31:16] nx, [47:32] ny,
                                // [62:48] nz, [65:63] band, [71:66] zero
    logic        m_axis_tlast;  // run_end
    logic        m_axis_tuser;  // [0] grid_done
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    heightfield_normal_and_band i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 clk = ~clk;

    // Shadow of the block: row store, position and registers
    logic [15:0] height_rows [3*SIDE_MAX];
    int unsigned cur_row;
    int unsigned cur_col;
    logic [8:0]  grid_reg;
    logic [15:0] spacing_reg;
    logic [15:0] scale_reg;

    point_t      pending_points[$];
    int          mismatches = 0;
    bit          no_idle = 1'b0;
    int unsigned items_sent = 0;

    // Band thresholds in percent of the height scale
    int unsigned band_pct [7] = '{10, 18, 22, 40, 60, 75, 88};

    function automatic int unsigned grid_side();
        if (grid_reg < 2) return 2;
        if (grid_reg > SIDE_MAX) return SIDE_MAX;
        return 32'(grid_reg);
    endfunction

    function automatic longint height_of(int r, int c, int unsigned n);
        if (r < 0) r = 0;
        if (r > n - 1) r = n - 1;
        if (c < 0) c = 0;
        if (c > n - 1) c = n - 1;
        return longint'(height_rows[(r % 3) * SIDE_MAX + c]);
    endfunction

    // Largest q with (2q-1)^2 * s <= m^2 * 2^32, i.e. 32768*m/sqrt(s) rounded
    // to nearest, then held at the Q1.15 ceiling
    function automatic logic [15:0] unit_q15(longint v, logic [127:0] s);
        logic [127:0] m2;
        logic [127:0] d;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        longint       m;
        m = (v < 0) ? -v : v;
        m2 = 128'(m) * 128'(m);
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            d = 128'(2 * mid - 1);
            if (d * d * s <= (m2 << 32)) lo = mid;
            else hi = mid - 1;
        end
        if (lo > 32767) lo = 32767;
        return (v < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic point_t normal_point(int unsigned r, int unsigned c,
                                            int unsigned n, bit done);
        point_t       p;
        longint       x;
        longint       y;
        longint       z;
        longint       h;
        logic [127:0] s;
        logic [15:0]  zq;
        x = 256 * (height_of(r, c - 1, n) - height_of(r, c + 1, n));
        y = 256 * (height_of(r - 1, c, n) - height_of(r + 1, c, n));
        z = 2 * longint'(spacing_reg);
        h = height_of(r, c, n);
        s = 128'(x * x) + 128'(y * y) + 128'(z * z);
        p.row = 8'(r);
        p.col = 8'(c);
        if (s == 0)
        begin
            p.nx = '0;
            p.ny = '0;
            p.nz = 15'h7FFF;
        end
        else
        begin
            p.nx = unit_q15(x, s);
            p.ny = unit_q15(y, s);
            zq = unit_q15(z, s);
            p.nz = zq[14:0];
        end
        p.band = 3'd7;
        for (int k = 6; k >= 0; k--)
            if (h * 100 <= longint'(band_pct[k]) * longint'(scale_reg)) p.band = 3'(k);
        p.run_end = 1'b0;
        p.grid_done = done;
        return p;
    endfunction

    // Store the height, queue the points it completes; returns their number
    function automatic int expect_points(logic [15:0] h);
        int unsigned n;
        int unsigned r;
        int unsigned c;
        int          cnt;
        n = grid_side();
        r = cur_row;
        c = cur_col;
        cnt = 0;
        if (r >= n || c >= n)
        begin
            r = 0;
            c = 0;
        end
        height_rows[(r % 3) * SIDE_MAX + c] = h;
        if (r >= 1)
        begin
            pending_points.insert(pending_points.size(), normal_point(r - 1, c, n, 1'b0));
            cnt++;
        end
        if (r == n - 1 && c >= 1)
        begin
            pending_points.insert(pending_points.size(), normal_point(r, c - 1, n, 1'b0));
            cnt++;
        end
        if (r == n - 1 && c == n - 1)
        begin
            pending_points.insert(pending_points.size(), normal_point(r, c, n, 1'b1));
            cnt++;
        end
        if (cnt > 0) pending_points[$].run_end = 1'b1;
        c++;
        if (c >= n)
        begin
            c = 0;
            r++;
            if (r >= n) r = 0;
        end
        cur_row = r;
        cur_col = c;
        return cnt;
    endfunction

    function automatic void report_mismatch(string what, longint want, longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    // Mostly short gaps, a few long ones; none in a no-idle stretch
    function automatic int unsigned gap_len();
        int unsigned pick;
        if (no_idle) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Enter and leave at a falling edge
    task automatic send_height(logic [15:0] h, output int produced);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= h;
        do @(posedge clk); while (!s_axis_tready);
        produced = expect_points(h);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_GRID_SIZE:
            begin
                grid_reg = val[8:0];
                cur_row = 0;
                cur_col = 0;
            end
            REG_SPACING: spacing_reg = val[15:0];
            REG_SCALE:   scale_reg = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Hold the sender until every point has arrived, then let the block
    // finish any item that causes no point
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Receiver side stalls
    int unsigned stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            stall_left <= gap_len();
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each point against the oldest expectation
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_points.size() == 0)
                report_mismatch("unexpected point, row", -1, m_axis_tdata[7:0]);
            else
            begin
                want = pending_points.pop_front();
                if (m_axis_tdata[7:0] != want.row)
                    report_mismatch("row", want.row, m_axis_tdata[7:0]);
                if (m_axis_tdata[15:8] != want.col)
                    report_mismatch("col", want.col, m_axis_tdata[15:8]);
                if (m_axis_tdata[31:16] != want.nx)
                    report_mismatch("normal_x", $signed(want.nx),
                                    $signed(m_axis_tdata[31:16]));
                if (m_axis_tdata[47:32] != want.ny)
                    report_mismatch("normal_y", $signed(want.ny),
                                    $signed(m_axis_tdata[47:32]));
                if (m_axis_tdata[62:48] != want.nz)
                    report_mismatch("normal_z", want.nz, m_axis_tdata[62:48]);
                if (m_axis_tdata[65:63] != want.band)
                    report_mismatch("band", want.band, m_axis_tdata[65:63]);
                if (m_axis_tlast != want.run_end)
                    report_mismatch("run_end", want.run_end, m_axis_tlast);
                if (m_axis_tuser != want.grid_done)
                    report_mismatch("grid_done", want.grid_done, m_axis_tuser);
            end
        end
    end

    // Directed table: flat grids with typed results, extremes, zero spacing,
    // zero scale, then a grid of side three at the register extremes
    step_t directed [DIRECTED_LEN] = '{
        '{0, REG_GRID_SIZE, 32'd0,     1, 15'h7FFF, 3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     1, 15'h7FFF, 3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     1, 15'h7FFF, 3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     1, 15'h7FFF, 3'd0},
        '{0, REG_GRID_SIZE, 32'hFFFF,  0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'hFFFF,  0, 15'd0,    3'd0},
        '{1, REG_SPACING,   32'd0,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     1, 15'h7FFF, 3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     1, 15'h7FFF, 3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     1, 15'h7FFF, 3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     1, 15'h7FFF, 3'd0},
        '{1, REG_SCALE,     32'd0,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd1,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'hFFFF,  0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     0, 15'd0,    3'd0},
        '{1, REG_GRID_SIZE, 32'd3,     0, 15'd0,    3'd0},
        '{1, REG_SPACING,   32'hFFFF,  0, 15'd0,    3'd0},
        '{1, REG_SCALE,     32'd1,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'hFFFF,  0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd1,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd2,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'h8000,  0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd0,     0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'h5555,  0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'hAAAA,  0, 15'd0,    3'd0},
        '{0, REG_GRID_SIZE, 32'd7,     0, 15'd0,    3'd0}
    };

    initial
    begin
        int          got;
        int unsigned n;
        int unsigned count;
        int unsigned mode;
        int unsigned base;
        bit          big_done;
        logic [15:0] h;
        point_t      p;

        grid_reg = GRID_RST;
        spacing_reg = SPACING_RST;
        scale_reg = SCALE_RST;
        cur_row = 0;
        cur_col = 0;
        big_done = 1'b0;

        // Hold reset, then release it away from the rising edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_LEN; i++)
        begin
            if (directed[i].is_cfg)
            begin
                drain();
                write_reg(directed[i].idx, directed[i].val);
            end
            else
            begin
                send_height(directed[i].val[15:0], got);
                // Flat rows: x and y must vanish, z and band as typed
                for (int k = 0; k < got && directed[i].typed; k++)
                begin
                    p = pending_points[pending_points.size() - got + k];
                    if (p.nx != 0 || p.ny != 0 || p.nz != directed[i].z_exp ||
                        p.band != directed[i].band_exp)
                        report_mismatch("typed normal_z", directed[i].z_exp, p.nz);
                end
            end
        end

        // Random phases; every phase starts from an idle block
        while (items_sent < DIRECTED_LEN + RANDOM_ITEMS)
        begin
            drain();
            no_idle = ($urandom_range(0, 3) == 0);
            if (!big_done && items_sent > 60)
            begin
                // One widest grid, clamped from above, only its first rows
                write_reg(REG_GRID_SIZE, $urandom_range(300, 511));
                big_done = 1'b1;
                count = 300;
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    write_reg(REG_GRID_SIZE, $urandom_range(0, 1));
                else
                    write_reg(REG_GRID_SIZE, $urandom_range(2, 7));
                n = grid_side();
                if ($urandom_range(0, 4) == 0) count = $urandom_range(1, n * n);
                else count = n * n * $urandom_range(1, 2);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_reg(REG_SPACING, 0);
                    1: write_reg(REG_SPACING, 16'hFFFF);
                    2: write_reg(REG_SPACING, $urandom_range(0, 16'hFFFF));
                    default: write_reg(REG_SPACING, $urandom_range(1, 2048));
                endcase
            end
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: write_reg(REG_SCALE, 0);
                    1: write_reg(REG_SCALE, 16'hFFFF);
                    default: write_reg(REG_SCALE, $urandom_range(1, 16'hFFFF));
                endcase
            end
            @(negedge clk);

            // Height shapes: full noise, gentle slopes around a base, or extremes
            mode = $urandom_range(0, 2);
            base = $urandom_range(0, 16'hFFFF);
            for (int unsigned i = 0; i < count; i++)
            begin
                case (mode)
                    0: h = 16'($urandom_range(0, 16'hFFFF));
                    1: h = 16'(base + $urandom_range(0, 63));
                    default: h = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                endcase
                send_height(h, got);
            end
        end

        drain();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
